// File: src/sobel_edge_magnitude_assert.svh
// Assertion macros for the Sobel edge magnitude block.
// Needs nothing; included by sobel_edge_magnitude, which checks itself.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/sem_pkg.sv
// Types, constants and the square root step for the Sobel edge magnitude block.
// No dependencies.
package sem_pkg;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int PIX_W     = 8;
	localparam int POS_W     = 10;
	localparam int GRAD_W    = 11;
	localparam int SQ_W      = 20;
	localparam int SUM_W     = 21;
	localparam int SQ_STAGES = 4;
	localparam int SQ_STEPS  = 2;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
	localparam logic [CFG_W-1:0] DIM_MIN      = 11'd3;
	localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;
	localparam logic [PIX_W-1:0] MAG_SAT      = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             done;
	} meta_t;

	typedef struct packed {
		logic [15:0] s;
		logic [9:0]  rem;
		logic [7:0]  root;
	} sq_core_t;

	typedef struct packed {
		sq_core_t core;
		logic     sat;
		meta_t    meta;
	} sq_stage_t;

	// One digit of the restoring integer square root, two radicand bits per step.
	function automatic sq_core_t sqrt_step(input sq_core_t cur);
		sq_core_t    nxt;
		logic [11:0] acc;
		logic [11:0] trial;
		acc   = {cur.rem, cur.s[15:14]};
		trial = {2'b00, cur.root, 2'b01};
		nxt.s = {cur.s[13:0], 2'b00};
		if (acc >= trial) begin
			nxt.rem  = 10'(acc - trial);
			nxt.root = {cur.root[6:0], 1'b1};
		end else begin
			nxt.rem  = acc[9:0];
			nxt.root = {cur.root[6:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// File: src/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream. One pixel item is
// accepted per clock while the result output is not stalled; the rate is set by
// the single read port of each line store, whose read for the next column is
// issued on the edge that accepts the current pixel. A result item passes the
// gradient, square, sum and four square root stages. Border pixels give no item.
// The magnitude saturates at 255. Line stores need no clearing after reset.
// Depends on sem_pkg and sobel_edge_magnitude_assert.svh.
`include "sobel_edge_magnitude_assert.svh"

module sobel_edge_magnitude
	import sem_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_ready,
	input  logic [PIX_W-1:0]     pixel_value,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [PIX_W-1:0]     edge_magnitude,
	output logic [POS_W-1:0]     center_col,
	output logic [POS_W-1:0]     center_row,
	output logic                 frame_done
);

	localparam int CNT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int LIM_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
	localparam logic [LIM_W-1:0] W_MAX = LIM_W'(MAX_WIDTH);
	localparam logic [LIM_W-1:0] W_MIN = LIM_W'(DIM_MIN);

	logic [CFG_W-1:0] width_q, height_q;
	logic [CNT_W-1:0] col_q, col_next;
	logic [POS_W-1:0] row_q;
	logic [PIX_W-1:0] win_q [0:5];

	logic [PIX_W-1:0] upper_mem  [0:MAX_WIDTH-1];
	logic [PIX_W-1:0] middle_mem [0:MAX_WIDTH-1];
	logic [PIX_W-1:0] upper_rd_q, middle_rd_q;
	logic [CNT_W-1:0] rd_addr;

	logic [LIM_W-1:0] w_ext, w_eff, col_inc;
	logic [CFG_W-1:0] h_eff, row_inc;
	logic             col_wrap, row_wrap, emit, pix_acc, pipe_en;

	logic signed [GRAD_W-1:0] t0, m0, b0, t1, b1, t2, m2, b2;
	logic signed [GRAD_W-1:0] gx, gy;

	logic                     v_s1, v_s2;
	logic signed [GRAD_W-1:0] gx_s1, gy_s1;
	meta_t                    meta_s1, meta_s2;
	logic [SQ_W-1:0]          gx2_s2, gy2_s2;
	logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
	logic [SUM_W-1:0]         sum;

	sq_stage_t sq_s   [0:SQ_STAGES];
	sq_stage_t sq_nxt [0:SQ_STAGES-1];
	logic      sq_v_s [0:SQ_STAGES];

	// frame limits and position advance
	assign w_ext    = LIM_W'(width_q);
	assign w_eff    = (w_ext < W_MIN) ? W_MIN : ((w_ext > W_MAX) ? W_MAX : w_ext);
	assign h_eff    = (height_q < DIM_MIN) ? DIM_MIN :
		((height_q > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_q);
	assign col_inc  = LIM_W'(col_q) + LIM_W'(1);
	assign row_inc  = CFG_W'(row_q) + CFG_W'(1);
	assign col_wrap = (col_inc >= w_eff);
	assign row_wrap = (row_inc >= h_eff);
	assign col_next = col_wrap ? '0 : col_inc[CNT_W-1:0];
	assign emit     = (col_q >= CNT_W'(2)) && (row_q >= POS_W'(2));

	assign pipe_en     = !sq_v_s[SQ_STAGES] || result_ready;
	assign pixel_ready = pipe_en;
	assign pix_acc     = pixel_valid && pipe_en;
	assign rd_addr     = pix_acc ? col_next : col_q;

	// window taps, zero-extended into the gradient width
	assign t0 = GRAD_W'(win_q[0]);
	assign m0 = GRAD_W'(win_q[1]);
	assign b0 = GRAD_W'(win_q[2]);
	assign t1 = GRAD_W'(win_q[3]);
	assign b1 = GRAD_W'(win_q[5]);
	assign t2 = GRAD_W'(upper_rd_q);
	assign m2 = GRAD_W'(middle_rd_q);
	assign b2 = GRAD_W'(pixel_value);

	assign gx = (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
	assign gy = (b0 + (b1 <<< 1) + b2) - (t0 + (t1 <<< 1) + t2);

	assign gx_sq = gx_s1 * gx_s1;
	assign gy_sq = gy_s1 * gy_s1;
	assign sum   = SUM_W'(gx2_s2) + SUM_W'(gy2_s2);

	always_comb begin
		for (int k = 0; k < SQ_STAGES; k++) begin
			sq_nxt[k] = sq_s[k];
			for (int j = 0; j < SQ_STEPS; j++) begin
				sq_nxt[k].core = sqrt_step(sq_nxt[k].core);
			end
		end
	end

	assign result_valid   = sq_v_s[SQ_STAGES];
	assign edge_magnitude = sq_s[SQ_STAGES].sat ? MAG_SAT : sq_s[SQ_STAGES].core.root;
	assign center_col     = sq_s[SQ_STAGES].meta.col;
	assign center_row     = sq_s[SQ_STAGES].meta.row;
	assign frame_done     = sq_s[SQ_STAGES].meta.done;

	// line stores: read ahead one column, write back the shifted column
	always_ff @(posedge clk) begin
		upper_rd_q  <= upper_mem[rd_addr];
		middle_rd_q <= middle_mem[rd_addr];
		if (pix_acc) begin
			upper_mem[col_q]  <= middle_rd_q;
			middle_mem[col_q] <= pixel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			for (int k = 0; k <= SQ_STAGES; k++) sq_v_s[k] <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (pix_acc) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= upper_rd_q;
				win_q[4] <= middle_rd_q;
				win_q[5] <= pixel_value;
				col_q    <= col_next;
				if (col_wrap) begin
					row_q <= row_wrap ? '0 : row_inc[POS_W-1:0];
				end
			end
			if (pipe_en) begin
				v_s1      <= pix_acc && emit;
				v_s2      <= v_s1;
				sq_v_s[0] <= v_s2;
				for (int k = 0; k < SQ_STAGES; k++) sq_v_s[k+1] <= sq_v_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			gx_s1        <= gx;
			gy_s1        <= gy;
			meta_s1.col  <= POS_W'(col_q - CNT_W'(1));
			meta_s1.row  <= row_q - POS_W'(1);
			meta_s1.done <= (col_inc == w_eff) && (row_inc == h_eff);
			gx2_s2       <= gx_sq[SQ_W-1:0];
			gy2_s2       <= gy_sq[SQ_W-1:0];
			meta_s2      <= meta_s1;
			sq_s[0].core.s    <= sum[15:0];
			sq_s[0].core.rem  <= '0;
			sq_s[0].core.root <= '0;
			sq_s[0].sat       <= (sum[SUM_W-1:16] != '0);
			sq_s[0].meta      <= meta_s2;
			for (int k = 0; k < SQ_STAGES; k++) sq_s[k+1] <= sq_nxt[k];
		end
	end

	`SEM_ASSERT_NOW(a_rd_wr_apart, clk, arst_n, pix_acc, col_next != col_q, "line store read-ahead hits the column being written")
	`SEM_ASSERT_NEXT(a_emit_enters, clk, arst_n, pix_acc && emit, v_s1, "interior pixel item did not enter the pipeline")
	`SEM_ASSERT_NEXT(a_frame_wrap, clk, arst_n, pix_acc && col_wrap && row_wrap, (col_q == '0) && (row_q == '0), "frame end did not return to origin")
	`SEM_ASSERT_NOW(a_root_rem, clk, arst_n, result_valid && !sq_s[SQ_STAGES].sat, {1'b0, sq_s[SQ_STAGES].core.rem} <= {2'b00, sq_s[SQ_STAGES].core.root, 1'b0}, "square root remainder exceeds twice the root")

endmodule

// File: tb/sv/sobel_gradient_tracker.sv
// Expected-result tracker for the Sobel edge magnitude testbench: line stores,
// window, position and geometry registers, plus the queue of pending edge items.
// Depends on sem_pkg.
package sem_tb_pkg;
	import sem_pkg::*;

	localparam int LINE_MAX = 1024;

	typedef struct {
		logic [PIX_W-1:0] mag;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             done;
	} edge_item_t;

	class gradient_tracker;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [PIX_W-1:0] upper_line [LINE_MAX];
		logic [PIX_W-1:0] middle_line [LINE_MAX];
		logic [PIX_W-1:0] cells [6];
		int unsigned      col;
		int unsigned      row;
		edge_item_t       pending_edges [$];
		int unsigned      failures;

		function new();
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (cells[i])
				cells[i] = '0;
			col      = 0;
			row      = 0;
			failures = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
			if (idx == REG_IMAGE_WIDTH)
				width_reg = value;
			else
				height_reg = value;
		endfunction

		function int unsigned width_now();
			if (width_reg < DIM_MIN)
				return DIM_MIN;
			if (width_reg > LINE_MAX)
				return LINE_MAX;
			return width_reg;
		endfunction

		function int unsigned height_now();
			if (height_reg < DIM_MIN)
				return DIM_MIN;
			if (height_reg > HEIGHT_LIMIT)
				return HEIGHT_LIMIT;
			return height_reg;
		endfunction

		function logic [PIX_W-1:0] floor_root(int unsigned sum);
			int unsigned r;
			int unsigned t;
			if (sum >= 65536)
				return MAG_SAT;
			r = 0;
			for (int b = 7; b >= 0; b--) begin
				t = r | (1 << b);
				if (t * t <= sum)
					r = t;
			end
			return PIX_W'(r);
		endfunction

		function void absorb_pixel(logic [PIX_W-1:0] px);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			int          top0, mid0, bot0, top1, bot1, top2, mid2, bot2, gx, gy;
			edge_item_t  e;
			w    = width_now();
			h    = height_now();
			c    = col % LINE_MAX;
			top2 = upper_line[c];
			mid2 = middle_line[c];
			bot2 = px;
			top0 = cells[0];
			mid0 = cells[1];
			bot0 = cells[2];
			top1 = cells[3];
			bot1 = cells[5];
			if (col >= 2 && row >= 2) begin
				gx     = (top2 - top0) + 2 * (mid2 - mid0) + (bot2 - bot0);
				gy     = (bot0 + 2 * bot1 + bot2) - (top0 + 2 * top1 + top2);
				e.mag  = floor_root(gx * gx + gy * gy);
				e.col  = POS_W'(col - 1);
				e.row  = POS_W'(row - 1);
				e.done = (col == w - 1) && (row == h - 1);
				pending_edges.push_back(e);
			end
			cells[0]       = cells[3];
			cells[1]       = cells[4];
			cells[2]       = cells[5];
			cells[3]       = upper_line[c];
			cells[4]       = middle_line[c];
			cells[5]       = px;
			upper_line[c]  = middle_line[c];
			middle_line[c] = px;
			// limits may have shrunk under the current position: wrap on advance
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_edge(logic [PIX_W-1:0] mag, logic [POS_W-1:0] c,
				logic [POS_W-1:0] r, logic done);
			edge_item_t e;
			if (pending_edges.size() == 0) begin
				$error("result item with nothing pending: col %0d row %0d", c, r);
				failures++;
				return;
			end
			e = pending_edges.pop_front();
			compare_field("edge_magnitude", POS_W'(e.mag), POS_W'(mag));
			compare_field("center_col", e.col, c);
			compare_field("center_row", e.row, r);
			compare_field("frame_done", POS_W'(e.done), POS_W'(done));
		endfunction
	endclass

endpackage

// File: tb/sv/sobel_edge_magnitude_test.sv
// Top-level testbench for sobel_edge_magnitude: drives pixel frames of many
// geometries with random idling on both handshakes and checks every edge item.
// Depends on sem_pkg, sem_tb_pkg and the sobel_edge_magnitude RTL.
module sobel_edge_magnitude_test
	import sem_pkg::*, sem_tb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 4000;

	typedef enum int {PAT_NOISE, PAT_SOFT, PAT_VSTEP, PAT_HSTEP, PAT_DIAG} pattern_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 pixel_valid  = 1'b0;
	logic                 pixel_ready;
	logic [PIX_W-1:0]     pixel_value  = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [PIX_W-1:0]     edge_magnitude;
	logic [POS_W-1:0]     center_col;
	logic [POS_W-1:0]     center_row;
	logic                 frame_done;

	gradient_tracker tracker = new();

	int unsigned send_idle_pct = 23;
	int unsigned recv_idle_pct = 68;
	int unsigned quiet_cycles  = 0;

	pattern_t         pat    = PAT_NOISE;
	logic [PIX_W-1:0] lvl_lo = '0;
	logic [PIX_W-1:0] lvl_hi = '1;
	int unsigned      split  = 1;

	// end of a row after a mid-frame shrink, then two tiny frames
	logic [PIX_W-1:0] tail_row [6]   = '{8'd40, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128};
	logic [PIX_W-1:0] tiny_frames [18] = '{
		8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255,
		8'd7, 8'd0, 8'd0,   8'd0, 8'd0, 8'd0,   8'd0, 8'd0, 8'd0
	};

	sobel_edge_magnitude u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel_valid    (pixel_valid),
		.pixel_ready    (pixel_ready),
		.pixel_value    (pixel_value),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.edge_magnitude (edge_magnitude),
		.center_col     (center_col),
		.center_row     (center_row),
		.frame_done     (frame_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (result_valid && result_ready)
			tracker.check_edge(edge_magnitude, center_col, center_row, frame_done);
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
		if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("sobel_edge_magnitude verification failed");
			$finish;
		end
	end

	task automatic push_pixel(input logic [PIX_W-1:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_value <= px;
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
		tracker.absorb_pixel(px);
	endtask

	task automatic drain_results();
		while (tracker.pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_IMAGE_WIDTH;
		cfg_data     <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		tracker.set_register(REG_IMAGE_WIDTH, w);
		tracker.set_register(REG_IMAGE_HEIGHT, h);
	endtask

	function automatic void pick_pattern();
		pat    = pattern_t'($urandom_range(4));
		lvl_lo = PIX_W'($urandom);
		lvl_hi = PIX_W'($urandom);
		split  = $urandom_range(40);
	endfunction

	function automatic logic [PIX_W-1:0] pattern_pixel();
		case (pat)
			PAT_NOISE: return PIX_W'($urandom);
			PAT_SOFT:  return lvl_lo + PIX_W'($urandom_range(15));
			PAT_VSTEP: return (tracker.col < split) ? lvl_lo : lvl_hi;
			PAT_HSTEP: return (tracker.row < split) ? lvl_lo : lvl_hi;
			default:   return (tracker.col + tracker.row < split) ? lvl_lo : lvl_hi;
		endcase
	endfunction

	task automatic send_items(input int n, input int pause_at);
		for (int i = 0; i < n; i++) begin
			if (tracker.col == 0 && tracker.row == 0)
				pick_pattern();
			if (i == pause_at) begin
				pixel_valid <= 1'b0;
				drain_results();
			end
			push_pixel(pattern_pixel());
		end
		pixel_valid <= 1'b0;
	endtask

	task automatic run_frames(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input int frames, input bit pause);
		int n;
		int pause_at;
		write_geometry(w, h);
		n        = frames * tracker.width_now() * tracker.height_now();
		pause_at = -1;
		if (pause)
			pause_at = $urandom_range(n - 1);
		send_items(n, pause_at);
		drain_results();
	endtask

	task automatic run_random_geometries(input int phases);
		for (int k = 0; k < phases; k++)
			run_frames(CFG_W'($urandom_range(3, 16)), CFG_W'($urandom_range(3, 8)),
				$urandom_range(1, 2), k == 2);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry 640x480: two rows and five pixels, then shrink mid-frame to 5x4
		send_items(2 * 640 + 5, -1);
		drain_results();
		write_geometry(CFG_W'(5), CFG_W'(4));
		foreach (tail_row[i])
			push_pixel(tail_row[i]);
		pixel_valid <= 1'b0;
		drain_results();
		write_geometry(CFG_W'(3), CFG_W'(3));
		foreach (tiny_frames[i])
			push_pixel(tiny_frames[i]);
		pixel_valid <= 1'b0;
		drain_results();

		run_frames(CFG_W'(3), CFG_W'(3), 10, 1'b0);
		run_frames(CFG_W'(0), CFG_W'(1), 10, 1'b1);

		send_idle_pct = 68;
		recv_idle_pct = 23;
		run_random_geometries(3);
		// shrink below the current column and row mid-frame
		run_frames(CFG_W'(20), CFG_W'(6), 0, 1'b0);
		send_items(72, -1);
		drain_results();
		write_geometry(CFG_W'(8), CFG_W'(3));
		send_items(1 + 2 * 8 * 3, -1);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_geometries(3);

		while (tracker.pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_edges.size() == 0)
			$display("sobel_edge_magnitude verification clean");
		else
			$display("sobel_edge_magnitude verification failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/sem_pkg.sv
src/sobel_edge_magnitude.sv
tb/sv/sobel_gradient_tracker.sv
tb/sv/sobel_edge_magnitude_test.sv
